// ===== hdl/ngel_pkg.sv =====
// ----------------------------------------------------------------------------
// ngel_pkg - shared types and constants for the nearest grid efficiency lookup
// Holds the request codes, the configuration register indexes, field widths
// and the result struct of the distance compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ngel_pkg;

    // Request kinds carried in tuser.
    localparam logic [1:0] OP_WR_AXIS = 2'd0;
    localparam logic [1:0] OP_WR_CELL = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // Configuration register indexes.
    localparam logic [3:0] CFG_SPEED_POINTS = 4'd0;
    localparam logic [3:0] CFG_TORQUE_ROWS  = 4'd1;

    localparam int VAL_W     = 24;  // speed and torque, signed Q15.8
    localparam int DIST_W    = VAL_W + 1;
    localparam int EFF_W     = 15;
    localparam int HIT_W     = 5;
    localparam int COUNT_W   = 6;
    // Wide enough to compare any index or count against a table size of 256.
    localparam int IDX_CMP_W = 9;

    typedef struct packed {
        logic [DIST_W-1:0] span;
        logic              closer;
    } ngel_cmp_t;

endpackage

`default_nettype wire

// ===== hdl/nearest_grid_efficiency_lookup.sv =====
// ----------------------------------------------------------------------------
// nearest_grid_efficiency_lookup - nearest cell lookup in a motor efficiency map
// Axis and cell writes are accepted back to back. A query's result comes from
// one shared distance unit that scans the speed axis, then one grid column.
// The input is not ready from a query's transfer until its result is registered.
// Reset (rst_n, asynchronous, active low) sets both counts to 1; map contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_grid_efficiency_lookup
    import ngel_pkg::*;
#(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Requests.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // row_index[4:0], column_index[9:5], speed_value[33:10], torque_value[57:34],
    // cell_eff[72:58], zero[79:73]
    input  wire logic [79:0] s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // Results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // efficiency_out[14:0], speed_hit[19:15], torque_hit[24:20], zero[31:25]
    output logic [31:0]      m_axis_tdata,
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_index,
    input  wire logic [5:0]  cfg_data
);

    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int GW    = EFF_W + VAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SPD  = 2'd1;
    localparam logic [1:0] S_TRQ  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [COUNT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [COUNT_W-1:0]  speed_points_reg, speed_points_next;
    logic [COUNT_W-1:0]  torque_rows_reg, torque_rows_next;
    logic                m_valid_reg, m_valid_next;

    logic [DIST_W-1:0]       best_reg, best_next;
    logic [CW-1:0]           best_c_reg, best_c_next;
    logic [RW-1:0]           best_r_reg, best_r_next;
    logic [EFF_W-1:0]        best_eff_reg, best_eff_next;
    logic signed [VAL_W-1:0] qspd_reg, qspd_next;
    logic signed [VAL_W-1:0] qtrq_reg, qtrq_next;
    logic [31:0]             m_data_reg, m_data_next;

    logic [1:0]          in_op;
    logic [HIT_W-1:0]    in_row;
    logic [HIT_W-1:0]    in_col;
    logic [VAL_W-1:0]    in_spd;
    logic [VAL_W-1:0]    in_trq;
    logic [EFF_W-1:0]    in_eff;
    logic                in_xfer;
    logic                col_ok;
    logic                row_ok;
    logic [COUNT_W-1:0]  ncol;
    logic [COUNT_W-1:0]  nrow;
    logic                issue;
    logic                load_out;

    logic              axis_we;
    logic [VAL_W-1:0]  axis_rdata;
    logic              grid_we;
    logic [AW-1:0]     grid_waddr;
    logic [AW-1:0]     grid_raddr;
    logic [GW-1:0]     grid_rdata;

    logic signed [VAL_W-1:0] cmp_sample;
    logic signed [VAL_W-1:0] cmp_target;
    ngel_cmp_t               cmp;

    assign in_row = s_axis_tdata[4:0];
    assign in_col = s_axis_tdata[9:5];
    assign in_spd = s_axis_tdata[33:10];
    assign in_trq = s_axis_tdata[57:34];
    assign in_eff = s_axis_tdata[72:58];
    assign in_op  = s_axis_tuser;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign col_ok = IDX_CMP_W'(in_col) < IDX_CMP_W'(MAX_COLUMNS);
    assign row_ok = IDX_CMP_W'(in_row) < IDX_CMP_W'(MAX_ROWS);

    // A count of zero means one entry; a count above the table size means all.
    always_comb
    begin
        if (speed_points_reg == '0)
        begin
            ncol = COUNT_W'(1);
        end
        else if (IDX_CMP_W'(speed_points_reg) > IDX_CMP_W'(MAX_COLUMNS))
        begin
            ncol = COUNT_W'(MAX_COLUMNS);
        end
        else
        begin
            ncol = speed_points_reg;
        end

        if (torque_rows_reg == '0)
        begin
            nrow = COUNT_W'(1);
        end
        else if (IDX_CMP_W'(torque_rows_reg) > IDX_CMP_W'(MAX_ROWS))
        begin
            nrow = COUNT_W'(MAX_ROWS);
        end
        else
        begin
            nrow = torque_rows_reg;
        end
    end

    assign axis_we    = in_xfer && (in_op == OP_WR_AXIS) && col_ok;
    assign grid_we    = in_xfer && (in_op == OP_WR_CELL) && col_ok && row_ok;
    assign grid_waddr = AW'(AW'(in_row) * AW'(MAX_COLUMNS)) + AW'(in_col);
    assign grid_raddr = AW'(AW'(cnt_reg) * AW'(MAX_COLUMNS)) + AW'(best_c_reg);

    ngel_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLUMNS)
    ) u_axis_ram (
        .clk   (clk),
        .we    (axis_we),
        .waddr (CW'(in_col)),
        .wdata (in_spd),
        .raddr (CW'(cnt_reg)),
        .rdata (axis_rdata)
    );

    // Torque in the low bits, efficiency above it.
    ngel_ram #(
        .WIDTH (GW),
        .DEPTH (CELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata ({in_eff, in_trq}),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    assign cmp_sample = (state_reg == S_SPD) ? signed'(axis_rdata)
                                             : signed'(grid_rdata[VAL_W-1:0]);
    assign cmp_target = (state_reg == S_SPD) ? qspd_reg : qtrq_reg;

    ngel_dist_cmp u_cmp (
        .sample (cmp_sample),
        .target (cmp_target),
        .best   (best_reg),
        .result (cmp)
    );

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pend_vld_next     = 1'b0;
        pend_idx_next     = cnt_reg;
        best_next         = best_reg;
        best_c_next       = best_c_reg;
        best_r_next       = best_r_reg;
        best_eff_next     = best_eff_reg;
        qspd_next         = qspd_reg;
        qtrq_next         = qtrq_reg;
        m_data_next       = m_data_reg;
        speed_points_next = speed_points_reg;
        torque_rows_next  = torque_rows_reg;
        issue             = 1'b0;
        load_out          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPEED_POINTS: speed_points_next = cfg_data;
                CFG_TORQUE_ROWS:  torque_rows_next  = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_op == OP_QUERY))
                begin
                    qspd_next  = signed'(in_spd);
                    qtrq_next  = signed'(in_trq);
                    cnt_next   = '0;
                    state_next = S_SPD;
                end
            end
            S_SPD:
            begin
                // One axis read goes out per cycle; its data is compared in the following cycle.
                issue         = cnt_reg < ncol;
                pend_vld_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
                if (pend_vld_reg)
                begin
                    if ((pend_idx_reg == '0) || cmp.closer)
                    begin
                        best_next   = cmp.span;
                        best_c_next = CW'(pend_idx_reg);
                    end
                    if (pend_idx_reg == ncol - COUNT_W'(1))
                    begin
                        cnt_next   = '0;
                        state_next = S_TRQ;
                    end
                end
            end
            S_TRQ:
            begin
                issue         = cnt_reg < nrow;
                pend_vld_next = issue;
                if (issue)
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
                if (pend_vld_reg)
                begin
                    if ((pend_idx_reg == '0) || cmp.closer)
                    begin
                        best_next     = cmp.span;
                        best_r_next   = RW'(pend_idx_reg);
                        best_eff_next = grid_rdata[GW-1:VAL_W];
                    end
                    if (pend_idx_reg == nrow - COUNT_W'(1))
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    load_out    = 1'b1;
                    m_data_next = {7'd0, HIT_W'(best_r_reg), HIT_W'(best_c_reg), best_eff_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            pend_vld_reg     <= 1'b0;
            pend_idx_reg     <= '0;
            speed_points_reg <= COUNT_W'(1);
            torque_rows_reg  <= COUNT_W'(1);
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            pend_vld_reg     <= pend_vld_next;
            pend_idx_reg     <= pend_idx_next;
            speed_points_reg <= speed_points_next;
            torque_rows_reg  <= torque_rows_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_c_reg   <= best_c_next;
        best_r_reg   <= best_r_next;
        best_eff_reg <= best_eff_next;
        qspd_reg     <= qspd_next;
        qtrq_reg     <= qtrq_next;
        m_data_reg   <= m_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ngel_ram.sv =====
// ----------------------------------------------------------------------------
// ngel_ram - simple dual port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ngel_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/ngel_dist_cmp.sv =====
// ----------------------------------------------------------------------------
// ngel_dist_cmp - absolute distance and compare unit
// Forms |sample - target| and flags whether it is below the best so far.
// Shared by the speed scan and the torque scan.
// ----------------------------------------------------------------------------
`default_nettype none

module ngel_dist_cmp
    import ngel_pkg::*;
(
    input  wire logic signed [VAL_W-1:0]  sample,
    input  wire logic signed [VAL_W-1:0]  target,
    input  wire logic        [DIST_W-1:0] best,
    output ngel_cmp_t                     result
);

    logic signed [DIST_W-1:0] diff;

    always_comb
    begin
        diff = DIST_W'(sample) - DIST_W'(target);
        // The magnitude of a 25-bit difference always fits 25 unsigned bits.
        result.span   = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
        result.closer = result.span < best;
    end

endmodule

`default_nettype wire

// ===== hdl/ngel_checker.sv =====
// ----------------------------------------------------------------------------
// ngel_checker - port level checks for the nearest grid efficiency lookup
// Watches the stream ports of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module ngel_checker
    import ngel_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A pending result stays until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped before its transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A query holds off further requests while it scans the map.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY)) |=> !s_axis_tready)
        else $error("request taken while a query is in progress");

    // Writes and unused codes do not stall the request channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_QUERY)) |=> s_axis_tready)
        else $error("write stalled the request channel");

    // A new result only comes out of a query in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a query");

endmodule

bind nearest_grid_efficiency_lookup ngel_checker u_ngel_checker (.*);

`default_nettype wire
